FILE: design/tamavg_pkg.sv
// Package for the three-axis moving average: shared constants, state types
// and the lane control bundle. No dependencies.
`default_nettype none

package tamavg_pkg;

    localparam int DEF_WINDOW      = 20;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int AXIS_COUNT      = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_FILTER_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_RUN,
        CTL_HOLD
    } ctl_state_t;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_SUM,
        LANE_LOAD,
        LANE_DIV,
        LANE_DONE
    } lane_state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic full;
    } lane_ctrl_t;

endpackage

`default_nettype wire

FILE: design/tamavg_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tamavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                    wdata,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

FILE: design/tamavg_lane.sv
// One axis lane: sample ring in RAM, running sum and a bit-serial signed divider.
// Depends on tamavg_pkg and tamavg_ram.
`default_nettype none

module tamavg_lane
    import tamavg_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    parameter int CNT_W       = $clog2(WINDOW + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lane_ctrl_t                    ctrl,
    input  wire logic        [SLOT_W-1:0]      slot,
    input  wire logic        [CNT_W-1:0]       count,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic                               done,
    output logic signed      [SAMPLE_BITS-1:0] quotient
);

    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    lane_state_t state_reg, state_next;

    logic signed [SUM_W-1:0]       sum_reg;
    logic        [SUM_W-1:0]       quo_reg;
    logic        [CNT_W-1:0]       rem_reg;
    logic        [CNT_W-1:0]       count_reg;
    logic        [SLOT_W-1:0]      slot_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          full_reg;
    logic                          neg_reg;
    logic        [STEP_W-1:0]      step_reg;

    logic        [SLOT_W-1:0]      ram_addr;
    logic                          ram_we;
    logic        [SAMPLE_BITS-1:0] ram_rdata;
    logic signed [SUM_W-1:0]       sample_ext;
    logic signed [SUM_W-1:0]       old_ext;
    logic        [CNT_W:0]         shifted;
    logic        [CNT_W:0]         diff;
    logic        [SAMPLE_BITS-1:0] quo_low;

    assign ram_addr = (state_reg == LANE_IDLE) ? slot : slot_reg;
    assign ram_we   = (state_reg == LANE_SUM);

    tamavg_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample_reg),
        .rdata (ram_rdata)
    );

    assign sample_ext = {{(SUM_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign old_ext    = full_reg ? {{(SUM_W - SAMPLE_BITS){ram_rdata[SAMPLE_BITS-1]}}, ram_rdata}
                                 : '0;
    assign shifted    = {rem_reg, quo_reg[SUM_W-1]};
    assign diff       = shifted - {1'b0, count_reg};
    assign quo_low    = quo_reg[SAMPLE_BITS-1:0];
    assign quotient   = neg_reg ? -quo_low : quo_low;

    always_comb
    begin
        state_next = state_reg;
        done       = 1'b0;
        case (state_reg)
            LANE_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = LANE_SUM;
                end
            end
            LANE_SUM:
            begin
                state_next = LANE_LOAD;
            end
            LANE_LOAD:
            begin
                state_next = LANE_DIV;
            end
            LANE_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = LANE_DONE;
                end
            end
            LANE_DONE:
            begin
                done       = 1'b1;
                state_next = LANE_IDLE;
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LANE_IDLE;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.clear)
            begin
                sum_reg <= '0;
            end
            else if (state_reg == LANE_SUM)
            begin
                sum_reg <= sum_reg - old_ext + sample_ext;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LANE_IDLE:
            begin
                slot_reg   <= slot;
                count_reg  <= count;
                sample_reg <= sample;
                full_reg   <= ctrl.full;
            end
            LANE_LOAD:
            begin
                neg_reg  <= sum_reg[SUM_W-1];
                quo_reg  <= sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
                rem_reg  <= '0;
                step_reg <= STEP_W'(SUM_W);
            end
            LANE_DIV:
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (!diff[CNT_W])
                begin
                    rem_reg <= diff[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[CNT_W-1:0];
                    quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/three_axis_moving_average.sv
// Top level of the three-axis moving average: APB register, sample sequencing,
// the three axis lanes and the output register. Depends on tamavg_pkg and tamavg_lane.
//
// Each accepted sample is averaged per axis over the last WINDOW samples (fewer
// during warm-up), with each mean truncated toward zero. A filtered sample keeps
// the block busy until every lane has divided its running sum by the held count,
// one quotient bit per cycle. With the filter disabled a sample is copied to the
// result register without division and the history is not touched. Writing 1
// to the enable register at address 0 empties the history at once; no clearing
// pass is needed. A result waits in the output register while the next sample
// is taken in.
`default_nettype none

module three_axis_moving_average
    import tamavg_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic        [APB_ADDR_W-1:0]  paddr,
    input  wire logic        [APB_DATA_W-1:0]  pwdata,
    output logic             [APB_DATA_W-1:0]  prdata,
    output logic                               pready,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_x_in,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_y_in,
    input  wire logic signed [SAMPLE_BITS-1:0] accel_z_in,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed      [SAMPLE_BITS-1:0] accel_x_out,
    output logic signed      [SAMPLE_BITS-1:0] accel_y_out,
    output logic signed      [SAMPLE_BITS-1:0] accel_z_out
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    ctl_state_t state_reg, state_next;

    logic                   enable_reg;
    logic [CNT_W-1:0]       held_reg;
    logic [SLOT_W-1:0]      oldest_reg;
    logic                   out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] res_reg  [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] sample_in [AXIS_COUNT];
    logic signed [SAMPLE_BITS-1:0] lane_quo [AXIS_COUNT];
    logic        [AXIS_COUNT-1:0]  lane_done;

    logic              cfg_write;
    logic              cfg_hit;
    logic              accept;
    logic              out_free;
    logic              full;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
    logic              res_load_in;
    logic              res_load_lane;
    logic              out_load;
    lane_ctrl_t        lane_ctrl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_hit   = (paddr[2] == REG_FILTER_ENABLE);
    assign prdata    = cfg_hit ? {{(APB_DATA_W - 1){1'b0}}, enable_reg} : '0;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (held_reg == CNT_W'(WINDOW));
    assign slot     = full ? oldest_reg : held_reg[SLOT_W-1:0];
    assign count    = full ? CNT_W'(WINDOW) : held_reg + CNT_W'(1);

    assign lane_ctrl.clear = cfg_write && cfg_hit && pwdata[0];
    assign lane_ctrl.start = accept && enable_reg;
    assign lane_ctrl.full  = full;

    assign sample_in[0] = accel_x_in;
    assign sample_in[1] = accel_y_in;
    assign sample_in[2] = accel_z_in;

    for (genvar a = 0; a < AXIS_COUNT; a++)
    begin : g_lane
        tamavg_lane #(
            .WINDOW      (WINDOW),
            .SAMPLE_BITS (SAMPLE_BITS),
            .SLOT_W      (SLOT_W),
            .CNT_W       (CNT_W)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (lane_ctrl),
            .slot     (slot),
            .count    (count),
            .sample   (sample_in[a]),
            .done     (lane_done[a]),
            .quotient (lane_quo[a])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        res_load_in   = 1'b0;
        res_load_lane = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (enable_reg)
                    begin
                        state_next = CTL_RUN;
                    end
                    else
                    begin
                        res_load_in = 1'b1;
                        state_next  = CTL_HOLD;
                    end
                end
            end
            CTL_RUN:
            begin
                if (&lane_done)
                begin
                    res_load_lane = 1'b1;
                    state_next    = CTL_HOLD;
                end
            end
            CTL_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            enable_reg    <= 1'b0;
            held_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && cfg_hit)
            begin
                enable_reg <= pwdata[0];
                if (pwdata[0])
                begin
                    held_reg   <= '0;
                    oldest_reg <= '0;
                end
            end
            else if (lane_ctrl.start)
            begin
                if (!full)
                begin
                    held_reg <= held_reg + CNT_W'(1);
                end
                else if (oldest_reg == SLOT_W'(WINDOW - 1))
                begin
                    oldest_reg <= '0;
                end
                else
                begin
                    oldest_reg <= oldest_reg + SLOT_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < AXIS_COUNT; a++)
        begin
            if (res_load_in)
            begin
                res_reg[a] <= sample_in[a];
            end
            else if (res_load_lane)
            begin
                res_reg[a] <= lane_quo[a];
            end
        end
        if (out_load)
        begin
            accel_x_out <= res_reg[0];
            accel_y_out <= res_reg[1];
            accel_z_out <= res_reg[2];
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
